[sv/idll_pkg.sv]
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types and codes for the indexed doubly linked list block.
// ----------------------------------------------------------------------------
package idll_pkg;

    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [2:0] MODE_APPEND  = 3'd0;
    localparam logic [2:0] MODE_PREPEND = 3'd1;
    localparam logic [2:0] MODE_INSERT  = 3'd2;
    localparam logic [2:0] MODE_READ    = 3'd3;
    localparam logic [2:0] MODE_POP_T   = 3'd4;
    localparam logic [2:0] MODE_POP_H   = 3'd5;
    localparam logic [2:0] MODE_REMOVE  = 3'd6;
    localparam logic [2:0] MODE_COUNT   = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         position;
        logic signed [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [8:0]         length;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_HEAD,
        OP_SET_TAIL,
        OP_WALK_INIT,
        OP_WALK_RD,
        OP_WALK_STEP,
        OP_SLOT_RD,
        OP_READ_DONE,
        OP_UNLINK,
        OP_FREE_RD,
        OP_TAKE,
        OP_LINK_TAIL,
        OP_LINK_HEAD,
        OP_INS_A,
        OP_INS_B,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       empty;
        logic       range_err;
        logic       full;
        logic       walk_done;
        logic       at_first;
    } dp_flags_t;

endpackage

[sv/idll_datapath.sv]
// ----------------------------------------------------------------------------
// idll_datapath
// Link memories, free stack, list pointers and result register.
// ----------------------------------------------------------------------------
module idll_datapath #(
    parameter int CAPACITY    = idll_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = idll_pkg::DEF_VALUE_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  idll_pkg::req_t     req,
    input  idll_pkg::dp_cmd_t  cmd,
    output idll_pkg::dp_flags_t flags,
    output idll_pkg::rsp_t     rsp
);
    import idll_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
    logic [SW-1:0]          fwd_mem  [CAPACITY];
    logic [SW-1:0]          bwd_mem  [CAPACITY];
    logic [SW-1:0]          free_mem [CAPACITY];

    logic [SW-1:0] first_reg, last_reg;
    logic [CW-1:0] count_reg, free_top_reg, low_reg;

    req_t                   req_reg;
    logic [SW-1:0]          s_reg, n_reg, fidx_reg;
    logic [CW-1:0]          i_reg;
    logic                   dir_reg, fresh_reg;
    logic [VALUE_WIDTH-1:0] val_rd_reg, res_reg;
    logic [SW-1:0]          fwd_rd_reg, bwd_rd_reg, free_rd_reg;
    rsp_t                   rsp_reg;

    logic [SW-1:0] nxt, n_take, take_idx, link_ra;
    logic          near;
    logic          fwd_we, bwd_we;
    logic [SW-1:0] fwd_wa, fwd_wd, bwd_wa, bwd_wd;

    assign near     = XW'(req_reg.position) < XW'(count_reg >> 1);
    assign nxt      = dir_reg ? fwd_rd_reg : bwd_rd_reg;
    assign n_take   = fresh_reg ? fidx_reg : free_rd_reg;
    assign take_idx = SW'(free_top_reg - 1'b1);
    assign link_ra  = (cmd.op == OP_WALK_STEP) ? nxt : s_reg;

    assign flags.mode      = req_reg.mode;
    assign flags.empty     = (count_reg == '0);
    assign flags.range_err = XW'(req_reg.position) >= XW'(count_reg);
    assign flags.full      = (free_top_reg == '0) || (count_reg >= CW'(CAPACITY));
    assign flags.walk_done = XW'(i_reg) == XW'(req_reg.position);
    assign flags.at_first  = (s_reg == first_reg);
    assign rsp             = rsp_reg;

    always_comb
    begin
        fwd_we = 1'b0;
        fwd_wa = '0;
        fwd_wd = '0;
        bwd_we = 1'b0;
        bwd_wa = '0;
        bwd_wd = '0;
        unique case (cmd.op)
            OP_LINK_TAIL:
            begin
                fwd_we = !flags.empty;
                fwd_wa = last_reg;
                fwd_wd = n_reg;
                bwd_we = !flags.empty;
                bwd_wa = n_reg;
                bwd_wd = last_reg;
            end
            OP_LINK_HEAD:
            begin
                bwd_we = !flags.empty;
                bwd_wa = first_reg;
                bwd_wd = n_reg;
                fwd_we = !flags.empty;
                fwd_wa = n_reg;
                fwd_wd = first_reg;
            end
            OP_UNLINK:
            begin
                fwd_we = (s_reg != first_reg);
                fwd_wa = bwd_rd_reg;
                fwd_wd = fwd_rd_reg;
                bwd_we = (s_reg != last_reg);
                bwd_wa = fwd_rd_reg;
                bwd_wd = bwd_rd_reg;
            end
            OP_INS_A:
            begin
                fwd_we = 1'b1;
                fwd_wa = bwd_rd_reg;
                fwd_wd = n_reg;
                bwd_we = 1'b1;
                bwd_wa = n_reg;
                bwd_wd = bwd_rd_reg;
            end
            OP_INS_B:
            begin
                fwd_we = 1'b1;
                fwd_wa = n_reg;
                fwd_wd = s_reg;
                bwd_we = 1'b1;
                bwd_wa = s_reg;
                bwd_wd = n_reg;
            end
            default:
            begin
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_TAKE)
            val_mem[n_take] <= VALUE_WIDTH'(req_reg.value_in);
        if (cmd.op == OP_SLOT_RD)
            val_rd_reg <= val_mem[s_reg];
    end

    always_ff @(posedge clk)
    begin
        if (fwd_we)
            fwd_mem[fwd_wa] <= fwd_wd;
        if (cmd.op == OP_WALK_RD || cmd.op == OP_WALK_STEP || cmd.op == OP_SLOT_RD)
            fwd_rd_reg <= fwd_mem[link_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bwd_we)
            bwd_mem[bwd_wa] <= bwd_wd;
        if (cmd.op == OP_WALK_RD || cmd.op == OP_WALK_STEP || cmd.op == OP_SLOT_RD)
            bwd_rd_reg <= bwd_mem[link_ra];
    end

    // entries below the low-water mark were never written and stand for their own index
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_UNLINK && free_top_reg < CW'(CAPACITY))
            free_mem[SW'(free_top_reg)] <= s_reg;
        if (cmd.op == OP_FREE_RD)
            free_rd_reg <= free_mem[take_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg    <= '0;
            last_reg     <= '0;
            count_reg    <= '0;
            free_top_reg <= CW'(CAPACITY);
            low_reg      <= CW'(CAPACITY);
        end
        else
        begin
            unique case (cmd.op)
                OP_FREE_RD:
                    free_top_reg <= free_top_reg - 1'b1;
                OP_TAKE:
                    if (CW'(fidx_reg) < low_reg)
                        low_reg <= CW'(fidx_reg);
                OP_LINK_TAIL:
                begin
                    if (flags.empty)
                        first_reg <= n_reg;
                    last_reg  <= n_reg;
                    count_reg <= count_reg + 1'b1;
                end
                OP_LINK_HEAD:
                begin
                    if (flags.empty)
                        last_reg <= n_reg;
                    first_reg <= n_reg;
                    count_reg <= count_reg + 1'b1;
                end
                OP_INS_B:
                    count_reg <= count_reg + 1'b1;
                OP_UNLINK:
                begin
                    if (count_reg == CW'(1))
                    begin
                        first_reg <= '0;
                        last_reg  <= '0;
                    end
                    else
                    begin
                        if (s_reg == first_reg)
                            first_reg <= fwd_rd_reg;
                        if (s_reg == last_reg)
                            last_reg <= bwd_rd_reg;
                    end
                    count_reg <= count_reg - 1'b1;
                    if (free_top_reg < CW'(CAPACITY))
                        free_top_reg <= free_top_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                req_reg <= req;
                res_reg <= '0;
            end
            OP_SET_HEAD:
                s_reg <= first_reg;
            OP_SET_TAIL:
                s_reg <= last_reg;
            OP_WALK_INIT:
            begin
                dir_reg <= near;
                s_reg   <= near ? first_reg : last_reg;
                i_reg   <= near ? '0 : count_reg - 1'b1;
            end
            OP_WALK_STEP:
            begin
                s_reg <= nxt;
                i_reg <= dir_reg ? i_reg + 1'b1 : i_reg - 1'b1;
            end
            OP_FREE_RD:
            begin
                fidx_reg  <= take_idx;
                fresh_reg <= CW'(take_idx) < low_reg;
            end
            OP_TAKE:
                n_reg <= n_take;
            OP_READ_DONE,
            OP_UNLINK:
                res_reg <= val_rd_reg;
            OP_FINISH:
            begin
                rsp_reg.status    <= cmd.status;
                rsp_reg.value_out <= 32'(res_reg);
                rsp_reg.length    <= 9'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

[sv/idll_ctrl.sv]
// ----------------------------------------------------------------------------
// idll_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module idll_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  idll_pkg::dp_flags_t flags,
    output idll_pkg::dp_cmd_t   cmd
);
    import idll_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WPRIME,
        S_WALK,
        S_FREE_RD,
        S_TAKE,
        S_LINK_T,
        S_LINK_H,
        S_SLOT_RD,
        S_INS_SEL,
        S_INS_B,
        S_UNLINK,
        S_READ,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] st_reg, st_next;
    logic       rsp_valid_reg, rsp_valid_next;

    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd.op         = OP_NONE;
        cmd.status     = st_reg;
        unique case (state_reg)
            S_IDLE:
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    st_next    = ST_OK;
                    state_next = S_DECODE;
                end
            S_DECODE:
                unique case (flags.mode)
                    MODE_APPEND,
                    MODE_PREPEND:
                        if (flags.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                            state_next = S_FREE_RD;
                    MODE_INSERT:
                        priority if (flags.range_err)
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_FINISH;
                        end
                        else if (flags.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.op     = OP_WALK_INIT;
                            state_next = S_WPRIME;
                        end
                    MODE_READ:
                        if (flags.range_err)
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.op     = OP_WALK_INIT;
                            state_next = S_WPRIME;
                        end
                    MODE_POP_T,
                    MODE_POP_H:
                        if (flags.empty)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.op     = (flags.mode == MODE_POP_T) ? OP_SET_TAIL : OP_SET_HEAD;
                            state_next = S_SLOT_RD;
                        end
                    MODE_REMOVE:
                        priority if (flags.empty)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_FINISH;
                        end
                        else if (flags.range_err)
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.op     = OP_WALK_INIT;
                            state_next = S_WPRIME;
                        end
                    MODE_COUNT:
                        state_next = S_FINISH;
                    default:
                        state_next = S_FINISH;
                endcase
            S_WPRIME:
            begin
                cmd.op     = OP_WALK_RD;
                state_next = S_WALK;
            end
            S_WALK:
                if (!flags.walk_done)
                    cmd.op = OP_WALK_STEP;
                else if (flags.mode == MODE_INSERT)
                    state_next = S_FREE_RD;
                else
                    state_next = S_SLOT_RD;
            S_FREE_RD:
            begin
                cmd.op     = OP_FREE_RD;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.op = OP_TAKE;
                priority if (flags.mode == MODE_APPEND)
                    state_next = S_LINK_T;
                else if (flags.mode == MODE_PREPEND)
                    state_next = S_LINK_H;
                else
                    state_next = S_SLOT_RD;
            end
            S_LINK_T:
            begin
                cmd.op     = OP_LINK_TAIL;
                state_next = S_FINISH;
            end
            S_LINK_H:
            begin
                cmd.op     = OP_LINK_HEAD;
                state_next = S_FINISH;
            end
            S_SLOT_RD:
            begin
                cmd.op = OP_SLOT_RD;
                priority if (flags.mode == MODE_READ)
                    state_next = S_READ;
                else if (flags.mode == MODE_INSERT)
                    state_next = S_INS_SEL;
                else
                    state_next = S_UNLINK;
            end
            S_INS_SEL:
                if (flags.at_first)
                begin
                    cmd.op     = OP_LINK_HEAD;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_INS_A;
                    state_next = S_INS_B;
                end
            S_INS_B:
            begin
                cmd.op     = OP_INS_B;
                state_next = S_FINISH;
            end
            S_UNLINK:
            begin
                cmd.op     = OP_UNLINK;
                state_next = S_FINISH;
            end
            S_READ:
            begin
                cmd.op     = OP_READ_DONE;
                state_next = S_FINISH;
            end
            S_FINISH:
                // hold until the result register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.op         = OP_FINISH;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[sv/indexed_doubly_linked_list_top.sv]
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_top
// A walk starts at the nearer end, so it covers at most count/2 links.
// Throughput: one request at a time; the next is taken while a result waits.
// Reset clears pointers, count and free stack at once; no clearing pass.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_top #(
    parameter int CAPACITY    = idll_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = idll_pkg::DEF_VALUE_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  idll_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output idll_pkg::rsp_t rsp
);
    import idll_pkg::*;

    dp_cmd_t   cmd;
    dp_flags_t flags;

    idll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    idll_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .flags (flags),
        .rsp   (rsp)
    );

endmodule

[sv/idll_checker.sv]
// ----------------------------------------------------------------------------
// idll_checker
// Port-level checks on the request and result channels of the linked list block.
// ----------------------------------------------------------------------------
module idll_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input idll_pkg::rsp_t rsp
);
    import idll_pkg::*;

    a_req_one: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request beat taken while busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.value_out == '0)
        else $error("failed request returned a value");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.length == '0)
        else $error("empty status with nonzero length");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.length != '0)
        else $error("full status with zero length");

endmodule

bind indexed_doubly_linked_list_top idll_checker u_idll_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[tb/sv/tb_indexed_doubly_linked_list_top.sv]
// ----------------------------------------------------------------------------
// tb_indexed_doubly_linked_list_top
// Self-checking bench for the indexed doubly linked list block. A queue-based
// shadow list predicts status, value and length of every request; random
// bursts and receiver stalls exercise the valid/ready handshakes.
// ----------------------------------------------------------------------------
module tb_indexed_doubly_linked_list_top;
    import idll_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP        = DEF_CAPACITY;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic signed [31:0] shadow_list[$];
    rsp_t               pending_rsp[$];
    int                 error_count = 0;
    int                 sent_beats = 0;
    int                 rsp_beats = 0;
    int                 idle_cycles = 0;
    int                 mode_hits[8];
    int                 status_hits[4];
    bit                 hold_off = 1'b0;
    bit                 bursty = 1'b1;
    bit                 done_flag = 1'b0;

    indexed_doubly_linked_list_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Shadow list update; returns the expected response.
    function automatic rsp_t list_apply(req_t r);
        rsp_t e;
        int   n;
        e = '0;
        n = shadow_list.size();
        case (r.mode)
            MODE_APPEND:
                if (n >= CAP) e.status = ST_FULL;
                else shadow_list.push_back(r.value_in);
            MODE_PREPEND:
                if (n >= CAP) e.status = ST_FULL;
                else shadow_list.push_front(r.value_in);
            MODE_INSERT:
                if (r.position >= n) e.status = ST_RANGE;
                else if (n >= CAP) e.status = ST_FULL;
                else shadow_list.insert(r.position, r.value_in);
            MODE_READ:
                if (r.position >= n) e.status = ST_RANGE;
                else e.value_out = shadow_list[r.position];
            MODE_POP_T:
                if (n == 0) e.status = ST_EMPTY;
                else e.value_out = shadow_list.pop_back();
            MODE_POP_H:
                if (n == 0) e.status = ST_EMPTY;
                else e.value_out = shadow_list.pop_front();
            MODE_REMOVE:
                if (n == 0) e.status = ST_EMPTY;
                else if (r.position >= n) e.status = ST_RANGE;
                else
                begin
                    e.value_out = shadow_list[r.position];
                    shadow_list.delete(r.position);
                end
            default: ;
        endcase
        e.length = 9'(shadow_list.size());
        return e;
    endfunction

    task automatic send_request(input logic [2:0] mode, input logic [7:0] pos,
                                input logic signed [31:0] value);
        req_t r;
        r.mode = mode;
        r.position = pos;
        r.value_in = value;
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        pending_rsp.push_back(list_apply(r));
        mode_hits[mode]++;
        sent_beats++;
        // random gap between bursts
        if (bursty && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    // Receiver stall pattern plus optional long hold-off.
    always @(posedge clk)
    begin
        if (hold_off) rsp_ready <= 1'b0;
        else rsp_ready <= ($urandom_range(0, 9) < 7) || !bursty;
    end

    // Response checker.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_beats++;
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected response beat");
                error_count++;
            end
            else
            begin
                rsp_t e;
                e = pending_rsp.pop_front();
                status_hits[rsp.status]++;
                if (rsp.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, rsp.status);
                    error_count++;
                end
                if (rsp.value_out !== e.value_out)
                begin
                    $error("value_out expected %0d actual %0d", e.value_out, rsp.value_out);
                    error_count++;
                end
                if (rsp.length !== e.length)
                begin
                    $error("length expected %0d actual %0d", e.length, rsp.length);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !done_flag)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed;
        send_request(MODE_POP_T, 8'd0, 32'sd0);
        send_request(MODE_POP_H, 8'd0, 32'sd0);
        send_request(MODE_REMOVE, 8'd255, 32'sd0);
        send_request(MODE_INSERT, 8'd0, 32'sd5);
        send_request(MODE_READ, 8'd0, 32'sd0);
        send_request(MODE_APPEND, 8'd0, 32'sh7fffffff);
        send_request(MODE_PREPEND, 8'd0, 32'sh80000000);
        send_request(MODE_APPEND, 8'hff, 32'shffffffff);
        send_request(MODE_INSERT, 8'd3, 32'sd1);
        send_request(MODE_INSERT, 8'd0, 32'sd2);
        send_request(MODE_INSERT, 8'd2, 32'sh55555555);
        send_request(MODE_READ, 8'd4, 32'sd0);
        send_request(MODE_READ, 8'd0, 32'sd0);
        send_request(MODE_READ, 8'd5, 32'sd0);
        send_request(MODE_COUNT, 8'hff, 32'shffffffff);
        send_request(MODE_REMOVE, 8'd1, 32'sd0);
        send_request(MODE_REMOVE, 8'd9, 32'sd0);
        send_request(MODE_POP_T, 8'd0, 32'sd0);
        send_request(MODE_POP_H, 8'd0, 32'sd0);
        send_request(MODE_REMOVE, 8'd0, 32'sd0);
        send_request(MODE_POP_H, 8'd0, 32'sd0);
        drain();
    endtask

    // Fill the pool, hit full on every insert path, then empty it.
    task automatic test_full_pool;
        while (shadow_list.size() < CAP)
            send_request(3'($urandom_range(0, 1)), 8'(CAP - 1), rand_value());
        send_request(MODE_APPEND, 8'd0, 32'sd1);
        send_request(MODE_PREPEND, 8'd0, 32'sd1);
        send_request(MODE_INSERT, 8'd128, 32'sd1);
        send_request(MODE_READ, 8'd255, 32'sd0);
        send_request(MODE_READ, 8'd127, 32'sd0);
        send_request(MODE_REMOVE, 8'd255, 32'sd0);
        send_request(MODE_INSERT, 8'd255, 32'sd9);
        while (shadow_list.size() > 0)
            send_request(3'($urandom_range(4, 6)), 8'($urandom_range(0, 255)), 32'sd0);
        drain();
    endtask

    task automatic test_backpressure;
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (12) send_request(MODE_APPEND, 8'd0, rand_value());
        join
        drain();
    endtask

    task automatic test_random;
        repeat (100)
        begin
            logic [2:0] m;
            int         n;
            n = shadow_list.size();
            m = 3'($urandom_range(0, 7));
            if (n < 20 && $urandom_range(0, 2) == 0) m = MODE_APPEND;
            if ($urandom_range(0, 99) < 3) bursty = ~bursty;
            send_request(m,
                ($urandom_range(0, 4) == 0 || n == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, n)),
                rand_value());
        end
        bursty = 1'b1;
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_full_pool();
        test_random();
        repeat (30) @(posedge clk);
        done_flag = 1'b1;
        $display("Sent %0d requests, checked %0d responses; modes seen %p",
                 sent_beats, rsp_beats, mode_hits);
        $display("Statuses seen (ok/range/empty/full): %p", status_hits);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
